>>> rtl/apsch_pkg.sv
// Shared types, constants and helper functions of the aging priority scheduler.
package apsch_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int ID_W       = 8;
    localparam int LEN_W      = 16;
    localparam int PRIO_W     = 16;
    localparam int WAIT_W     = 16;
    localparam int GAIN_W     = 4;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;

    localparam logic [GAIN_W-1:0] RUN_GAIN_RST  = 4'd1;
    localparam logic [GAIN_W-1:0] WAIT_GAIN_RST = 4'd2;

    // Command codes of an input item.
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RUN_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_GAIN = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        RES_IDLE     = 3'd0,
        RES_RAN      = 3'd1,
        RES_DONE     = 3'd2,
        RES_ADDED    = 3'd3,
        RES_REJECTED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_SCAN1,
        CS_DECIDE,
        CS_SCAN2,
        CS_FINISH
    } ctrl_state_t;

    // Running result of the compare chain; indexes travel on separate ports.
    typedef struct packed {
        logic              best_found;
        logic [PRIO_W-1:0] best_prio;
        logic              free_found;
        logic [ID_W-1:0]   sel_id;
        logic [WAIT_W-1:0] sel_wait;
        logic [LEN_W-1:0]  sel_rem;
        logic [PRIO_W-1:0] sel_prio;
    } cand_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic              wr;
        logic              tick;
        logic              clr;
        logic              skip_en;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  burst;
        logic [GAIN_W-1:0] run_gain;
        logic [GAIN_W-1:0] wait_gain;
    } cell_ctl_t;

    function automatic logic [PRIO_W-1:0] sat_add(input logic [PRIO_W-1:0] a,
                                                 input logic [GAIN_W-1:0] b);
        logic [PRIO_W:0] s;
        s = {1'b0, a} + {{(PRIO_W + 1 - GAIN_W){1'b0}}, b};
        return s[PRIO_W] ? {PRIO_W{1'b1}} : s[PRIO_W-1:0];
    endfunction

endpackage

>>> rtl/apsch_cell.sv
// One process slot of the scheduler with its stage of the compare chain.
module apsch_cell #(
    parameter int SLOTS = apsch_pkg::SLOTS_DEF,
    parameter int IDX   = 0,
    parameter int IW    = $clog2(SLOTS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  apsch_pkg::cell_ctl_t ctl,
    input  logic [IW-1:0]       tgt_idx,
    input  logic [IW-1:0]       wr_idx,
    input  apsch_pkg::cand_t    cand_in,
    input  logic [IW-1:0]       best_idx_in,
    input  logic [IW-1:0]       free_idx_in,
    output apsch_pkg::cand_t    cand_out,
    output logic [IW-1:0]       best_idx_out,
    output logic [IW-1:0]       free_idx_out
);
    import apsch_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic              valid_reg, valid_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    cand_t             cand_reg, cand_next;
    logic [IW-1:0]     best_idx_reg, best_idx_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;
    logic              mine;
    logic              eligible;

    assign mine     = (tgt_idx == MY_IDX);
    assign eligible = valid_reg && !(ctl.skip_en && mine);

    // Slot state update.
    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        rem_next   = rem_reg;
        prio_next  = prio_reg;
        wait_next  = wait_reg;
        if (ctl.wr && (wr_idx == MY_IDX))
        begin
            valid_next = 1'b1;
            id_next    = ctl.id;
            rem_next   = ctl.burst;
            prio_next  = '0;
            wait_next  = '0;
        end
        else if (ctl.tick && valid_reg)
        begin
            if (mine)
            begin
                if (rem_reg != '0)
                begin
                    rem_next = rem_reg - LEN_W'(1);
                end
                prio_next = sat_add(prio_reg, ctl.run_gain);
            end
            else
            begin
                prio_next = sat_add(prio_reg, ctl.wait_gain);
                wait_next = sat_add(wait_reg, GAIN_W'(1));
            end
        end
        if (ctl.clr && mine)
        begin
            valid_next = 1'b0;
        end
    end

    // Chain stage: earlier slots win ties, so only a strictly higher priority takes over.
    always_comb
    begin
        cand_next     = cand_in;
        best_idx_next = best_idx_in;
        free_idx_next = free_idx_in;
        if (eligible && (!cand_in.best_found || (prio_reg > cand_in.best_prio)))
        begin
            cand_next.best_found = 1'b1;
            cand_next.best_prio  = prio_reg;
            best_idx_next        = MY_IDX;
        end
        if (!cand_in.free_found && !valid_reg)
        begin
            cand_next.free_found = 1'b1;
            free_idx_next        = MY_IDX;
        end
        if (mine)
        begin
            cand_next.sel_id   = id_reg;
            cand_next.sel_wait = wait_reg;
            cand_next.sel_rem  = rem_reg;
            cand_next.sel_prio = prio_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            cand_reg     <= '0;
            best_idx_reg <= '0;
            free_idx_reg <= '0;
        end
        else
        begin
            valid_reg    <= valid_next;
            cand_reg     <= cand_next;
            best_idx_reg <= best_idx_next;
            free_idx_reg <= free_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        rem_reg  <= rem_next;
        prio_reg <= prio_next;
        wait_reg <= wait_next;
    end

    assign cand_out     = cand_reg;
    assign best_idx_out = best_idx_reg;
    assign free_idx_out = free_idx_reg;

endmodule

>>> rtl/apsch_ctrl.sv
// Sequencer of the scheduler: scan timing, decisions and the result register.
module apsch_ctrl #(
    parameter int SLOTS = apsch_pkg::SLOTS_DEF,
    parameter int IW    = $clog2(SLOTS)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            command,
    input  logic [apsch_pkg::ID_W-1:0]      process_id,
    input  logic [apsch_pkg::LEN_W-1:0]     burst_length,
    input  logic [apsch_pkg::GAIN_W-1:0]    run_gain,
    input  logic [apsch_pkg::GAIN_W-1:0]    wait_gain,
    input  apsch_pkg::cand_t                cand,
    input  logic [IW-1:0]                   best_idx,
    output apsch_pkg::cell_ctl_t            ctl,
    output logic [IW-1:0]                   tgt_idx,
    output logic                            busy,
    output logic                            done,
    output logic [apsch_pkg::STATUS_W-1:0]  status,
    output logic [apsch_pkg::ID_W-1:0]      out_id,
    output logic [apsch_pkg::WAIT_W-1:0]    wait_total,
    output logic [apsch_pkg::LEN_W-1:0]     remaining_left
);
    import apsch_pkg::*;

    localparam logic [IW-1:0] CNT_LAST = IW'(SLOTS - 1);

    ctrl_state_t       state_reg, state_next;
    logic [IW-1:0]     cnt_reg, cnt_next;
    logic              cmd_reg, cmd_next;
    logic [ID_W-1:0]   pid_reg, pid_next;
    logic [LEN_W-1:0]  burst_reg, burst_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic              cur_valid_reg, cur_valid_next;
    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            cnt_reg       <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        pid_reg    <= pid_next;
        burst_reg  <= burst_next;
        status_reg <= status_next;
        out_id_reg <= out_id_next;
        wait_reg   <= wait_next;
        rem_reg    <= rem_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        pid_next       = pid_reg;
        burst_next     = burst_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        out_id_next    = out_id_reg;
        wait_next      = wait_reg;
        rem_next       = rem_reg;
        tgt_idx        = cur_reg;

        ctl           = '0;
        ctl.id        = pid_reg;
        ctl.burst     = burst_reg;
        ctl.run_gain  = run_gain;
        ctl.wait_gain = wait_gain;

        case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    pid_next   = process_id;
                    burst_next = burst_length;
                    cnt_next   = '0;
                    state_next = CS_SCAN1;
                end
            end
            CS_SCAN1:
            begin
                cnt_next = cnt_reg + IW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = CS_DECIDE;
                end
            end
            CS_DECIDE:
            begin
                state_next = CS_IDLE;
                done_next  = 1'b1;
                if (cmd_reg == CMD_ADD)
                begin
                    out_id_next = pid_reg;
                    wait_next   = '0;
                    if ((burst_reg == '0) || !cand.free_found)
                    begin
                        status_next = RES_REJECTED;
                        rem_next    = '0;
                    end
                    else
                    begin
                        ctl.wr      = 1'b1;
                        status_next = RES_ADDED;
                        rem_next    = burst_reg;
                    end
                end
                else if (!cur_valid_reg && !cand.best_found)
                begin
                    status_next = RES_IDLE;
                    out_id_next = '0;
                    wait_next   = '0;
                    rem_next    = '0;
                end
                else
                begin
                    // Pick a current process if none is held, then run one unit.
                    if (!cur_valid_reg)
                    begin
                        tgt_idx  = best_idx;
                        cur_next = best_idx;
                    end
                    cur_valid_next = 1'b1;
                    ctl.tick       = 1'b1;
                    done_next      = 1'b0;
                    cnt_next       = '0;
                    state_next     = CS_SCAN2;
                end
            end
            CS_SCAN2:
            begin
                ctl.skip_en = 1'b1;
                cnt_next    = cnt_reg + IW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = CS_FINISH;
                end
            end
            CS_FINISH:
            begin
                ctl.skip_en = 1'b1;
                state_next  = CS_IDLE;
                done_next   = 1'b1;
                out_id_next = cand.sel_id;
                wait_next   = cand.sel_wait;
                if (cand.sel_rem == '0)
                begin
                    ctl.clr        = 1'b1;
                    status_next    = RES_DONE;
                    rem_next       = '0;
                    cur_valid_next = cand.best_found;
                    if (cand.best_found)
                    begin
                        cur_next = best_idx;
                    end
                end
                else
                begin
                    status_next = RES_RAN;
                    rem_next    = cand.sel_rem;
                    if (cand.best_found && (cand.best_prio >= cand.sel_prio))
                    begin
                        cur_next = best_idx;
                    end
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    assign busy           = (state_reg != CS_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign out_id         = out_id_reg;
    assign wait_total     = wait_reg;
    assign remaining_left = rem_reg;

endmodule

>>> rtl/aging_priority_scheduler_top.sv
// Top level of the aging priority scheduler: configuration, sequencer and slot chain.
// An add item and a tick with no process are decided after one scan of the slot table;
// any other tick runs one unit, scans the table a second time, and then strobes its result.
// Each scan lets the registered compare chain settle through all of its slot stages.
// The receiver cannot stall; the next item is accepted in the cycle its predecessor's result is on the ports.
// Reset empties all slots, drops the current process and sets the gains (run 1, wait 2) at once.
module aging_priority_scheduler_top #(
    parameter int SLOTS = apsch_pkg::SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             command,
    input  logic [apsch_pkg::ID_W-1:0]       process_id,
    input  logic [apsch_pkg::LEN_W-1:0]      burst_length,
    output logic                             done,
    output logic [apsch_pkg::STATUS_W-1:0]   status,
    output logic [apsch_pkg::ID_W-1:0]       out_id,
    output logic [apsch_pkg::WAIT_W-1:0]     wait_total,
    output logic [apsch_pkg::LEN_W-1:0]      remaining_left,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [apsch_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apsch_pkg::GAIN_W-1:0]     cfg_data
);
    import apsch_pkg::*;

    localparam int IW = $clog2(SLOTS);

    logic [GAIN_W-1:0] run_gain_reg, run_gain_next;
    logic [GAIN_W-1:0] wait_gain_reg, wait_gain_next;

    cell_ctl_t     ctl;
    logic [IW-1:0] tgt_idx;

    // The chain runs from slot 0 upward; stage k holds the best candidate among
    // slots 0 to k-1, the lowest free slot, and the fields of the targeted slot.
    cand_t         cand_chain [SLOTS+1];
    logic [IW-1:0] best_chain [SLOTS+1];
    logic [IW-1:0] free_chain [SLOTS+1];

    // The configuration port never stalls; writes to unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        run_gain_next  = run_gain_reg;
        wait_gain_next = wait_gain_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_RUN_GAIN:  run_gain_next  = cfg_data;
                REG_WAIT_GAIN: wait_gain_next = cfg_data;
                default:       run_gain_next  = run_gain_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_gain_reg  <= RUN_GAIN_RST;
            wait_gain_reg <= WAIT_GAIN_RST;
        end
        else
        begin
            run_gain_reg  <= run_gain_next;
            wait_gain_reg <= wait_gain_next;
        end
    end

    // The sequencer lets the chain settle after any change of slot state so the
    // last chain stage reflects the whole table before it decides.
    apsch_ctrl #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .command        (command),
        .process_id     (process_id),
        .burst_length   (burst_length),
        .run_gain       (run_gain_reg),
        .wait_gain      (wait_gain_reg),
        .cand           (cand_chain[SLOTS]),
        .best_idx       (best_chain[SLOTS]),
        .ctl            (ctl),
        .tgt_idx        (tgt_idx),
        .busy           (busy),
        .done           (done),
        .status         (status),
        .out_id         (out_id),
        .wait_total     (wait_total),
        .remaining_left (remaining_left)
    );

    assign cand_chain[0] = '0;
    assign best_chain[0] = '0;
    assign free_chain[0] = '0;

    // An add writes the lowest free slot, which is what the chain's end reports.
    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        apsch_cell #(
            .SLOTS (SLOTS),
            .IDX   (k),
            .IW    (IW)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .tgt_idx      (tgt_idx),
            .wr_idx       (free_chain[SLOTS]),
            .cand_in      (cand_chain[k]),
            .best_idx_in  (best_chain[k]),
            .free_idx_in  (free_chain[k]),
            .cand_out     (cand_chain[k+1]),
            .best_idx_out (best_chain[k+1]),
            .free_idx_out (free_chain[k+1])
        );
    end

`ifndef SYNTHESIS
    // A result is only produced as the sequencer returns to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while the sequencer is busy");

    // No item completes right after its acceptance.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result strobe right after an accepted item");

    // An accepted add always carries its nonzero burst back.
    a_added_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == RES_ADDED)) |-> (remaining_left != '0))
        else $error("added process reported with zero burst");

    // A process that ran but did not complete still has work left.
    a_ran_left: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == RES_RAN)) |-> (remaining_left != '0))
        else $error("running process reported with zero remaining burst");
`endif

endmodule

>>> bench/schedule_checker.sv
// Checker that predicts the scheduler's result for every accepted item and compares it.
module schedule_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic                             command,
    input  logic [apsch_pkg::ID_W-1:0]       process_id,
    input  logic [apsch_pkg::LEN_W-1:0]      burst_length,
    input  logic                             done,
    input  logic [apsch_pkg::STATUS_W-1:0]   status,
    input  logic [apsch_pkg::ID_W-1:0]       out_id,
    input  logic [apsch_pkg::WAIT_W-1:0]     wait_total,
    input  logic [apsch_pkg::LEN_W-1:0]      remaining_left,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [apsch_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apsch_pkg::GAIN_W-1:0]     cfg_data,
    output int                               mismatch_count,
    output int                               results_owed
);
    timeunit 1ns;
    timeprecision 1ps;
    import apsch_pkg::*;

    localparam int NUM_SLOTS = SLOTS_DEF;
    localparam int SAT_MAX   = (1 << PRIO_W) - 1;

    typedef struct {
        status_t           status;
        logic [ID_W-1:0]   id;
        logic [WAIT_W-1:0] waited;
        logic [LEN_W-1:0]  left;
    } sched_result_t;

    // Predicted process table and configuration.
    logic                proc_live   [NUM_SLOTS];
    logic [ID_W-1:0]     proc_id     [NUM_SLOTS];
    logic [LEN_W-1:0]    proc_left   [NUM_SLOTS];
    logic [PRIO_W-1:0]   proc_prio   [NUM_SLOTS];
    logic [WAIT_W-1:0]   proc_waited [NUM_SLOTS];
    int                  running_slot;
    logic                running_live;
    logic [GAIN_W-1:0]   gain_run;
    logic [GAIN_W-1:0]   gain_wait;

    sched_result_t       due_results [$];
    sched_result_t       want;

    function automatic logic [PRIO_W-1:0] bump(input logic [PRIO_W-1:0] a, input int b);
        int s;
        s = int'(a) + b;
        return (s > SAT_MAX) ? PRIO_W'(SAT_MAX) : PRIO_W'(s);
    endfunction

    // Highest-priority live slot other than skip, lowest index on a tie;
    // NUM_SLOTS when there is none.
    function automatic int pick_best(input int skip);
        int best;
        best = NUM_SLOTS;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (proc_live[k] && k != skip &&
                (best == NUM_SLOTS || proc_prio[k] > proc_prio[best]))
                best = k;
        end
        return best;
    endfunction

    function automatic sched_result_t schedule_item(input logic cmd,
                                                    input logic [ID_W-1:0] pid,
                                                    input logic [LEN_W-1:0] burst);
        sched_result_t r;
        int free_slot;
        int nxt;
        int c;
        if (cmd == CMD_ADD)
        begin
            free_slot = NUM_SLOTS;
            for (int k = NUM_SLOTS - 1; k >= 0; k--)
            begin
                if (!proc_live[k])
                    free_slot = k;
            end
            if (burst == '0 || free_slot == NUM_SLOTS)
            begin
                r = '{status: RES_REJECTED, id: pid, waited: '0, left: '0};
                return r;
            end
            proc_live[free_slot]   = 1'b1;
            proc_id[free_slot]     = pid;
            proc_left[free_slot]   = burst;
            proc_prio[free_slot]   = '0;
            proc_waited[free_slot] = '0;
            r = '{status: RES_ADDED, id: pid, waited: '0, left: burst};
            return r;
        end

        // A tick with no current process picks one first, or reports idle.
        if (!(running_live && proc_live[running_slot]))
        begin
            nxt = pick_best(NUM_SLOTS);
            if (nxt == NUM_SLOTS)
            begin
                running_live = 1'b0;
                r = '{status: RES_IDLE, id: '0, waited: '0, left: '0};
                return r;
            end
            running_slot = nxt;
            running_live = 1'b1;
        end
        c = running_slot;

        if (proc_left[c] != '0)
            proc_left[c] = proc_left[c] - 1'b1;
        proc_prio[c] = bump(proc_prio[c], int'(gain_run));
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (proc_live[k] && k != c)
            begin
                proc_prio[k]   = bump(proc_prio[k], int'(gain_wait));
                proc_waited[k] = bump(proc_waited[k], 1);
            end
        end

        if (proc_left[c] == '0)
        begin
            r = '{status: RES_DONE, id: proc_id[c], waited: proc_waited[c], left: '0};
            proc_live[c] = 1'b0;
            running_live = 1'b0;
        end
        else
            r = '{status: RES_RAN, id: proc_id[c], waited: proc_waited[c], left: proc_left[c]};

        // A waiting process takes over on a priority tie or better.
        nxt = pick_best(c);
        if (!running_live)
        begin
            if (nxt != NUM_SLOTS)
            begin
                running_slot = nxt;
                running_live = 1'b1;
            end
        end
        else if (nxt != NUM_SLOTS && proc_prio[nxt] >= proc_prio[c])
            running_slot = nxt;
        return r;
    endfunction

    function automatic void check_field(input string name, input int expected, input int actual);
        if (expected != actual)
        begin
            $error("%s: expected %0d, actual %0d", name, expected, actual);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_SLOTS; k++)
                proc_live[k] = 1'b0;
            running_slot = 0;
            running_live = 1'b0;
            gain_run     = RUN_GAIN_RST;
            gain_wait    = WAIT_GAIN_RST;
            due_results.delete();
            results_owed = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_RUN_GAIN)
                    gain_run = cfg_data;
                else if (cfg_index == REG_WAIT_GAIN)
                    gain_wait = cfg_data;
            end
            if (done)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result strobe with no item outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("status", int'(want.status), int'(status));
                    check_field("out_id", int'(want.id), int'(out_id));
                    check_field("wait_total", int'(want.waited), int'(wait_total));
                    check_field("remaining_left", int'(want.left), int'(remaining_left));
                end
            end
            if (start && !busy)
                due_results.push_back(schedule_item(command, process_id, burst_length));
            results_owed = due_results.size();
        end
    end

endmodule

>>> bench/testbench.sv
// Top of the scheduler regression: clock, reset, item and register stimulus, and the verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import apsch_pkg::*;

    // The register index just past the real ones; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_WAIT_GAIN + 1'b1;

    // The limit leaves several times the slowest item plus the longest sender
    // gap, over about eleven hundred items.
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE      = 2 * SLOTS_DEF + 4;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  command;
    logic [ID_W-1:0]       process_id;
    logic [LEN_W-1:0]      burst_length;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [ID_W-1:0]       out_id;
    logic [WAIT_W-1:0]     wait_total;
    logic [LEN_W-1:0]      remaining_left;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [GAIN_W-1:0]     cfg_data;

    int mismatch_count;
    int results_owed;
    int cycle_count;
    int sender_idle_pct;

    aging_priority_scheduler_top #(
        .SLOTS (SLOTS_DEF)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .process_id     (process_id),
        .burst_length   (burst_length),
        .done           (done),
        .status         (status),
        .out_id         (out_id),
        .wait_total     (wait_total),
        .remaining_left (remaining_left),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // The checker sits beside the block, sees the same wires, and reports back
    // how many results are still owed and how many mismatches it has found.
    schedule_checker sched_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .process_id     (process_id),
        .burst_length   (burst_length),
        .done           (done),
        .status         (status),
        .out_id         (out_id),
        .wait_total     (wait_total),
        .remaining_left (remaining_left),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("aging_priority_scheduler_top regression: fail");
            $finish;
        end
    end

    // Waits, with start low, until the block has returned every result it owes.
    task automatic drain();
        start = 1'b0;
        while (results_owed != 0)
            @(negedge clk);
    endtask

    // Offers one item. All inputs move on the falling edge; the item counts as
    // taken at the first rising edge that sees busy low. A random hold-off in
    // front of the item is usually short, but now and then long enough to land
    // anywhere inside the block's scan of the slot table.
    task automatic send_item(input logic cmd, input logic [ID_W-1:0] pid,
                             input logic [LEN_W-1:0] len);
        int gap;
        gap = 0;
        if ($urandom_range(99, 0) < sender_idle_pct)
            gap = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 1) : $urandom_range(3, 1);
        if (gap != 0)
        begin
            start = 1'b0;
            repeat (gap)
            begin
                // Junk on the item fields while start is low must be ignored.
                command      = 1'($urandom);
                process_id   = ID_W'($urandom);
                burst_length = LEN_W'($urandom);
                @(negedge clk);
            end
        end
        start        = 1'b1;
        command      = cmd;
        process_id   = pid;
        burst_length = len;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Loads both gains, and optionally pokes the unused index as well. The
    // block is drained first so that no item is in flight during the writes.
    task automatic program_gains(input logic [GAIN_W-1:0] run_g,
                                 input logic [GAIN_W-1:0] wait_g,
                                 input bit touch_spare);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [GAIN_W-1:0]    val [3];
        int                   n;
        idx[0] = REG_SPARE;
        val[0] = GAIN_W'($urandom);
        idx[1] = REG_RUN_GAIN;
        val[1] = run_g;
        idx[2] = REG_WAIT_GAIN;
        val[2] = wait_g;
        drain();
        for (int w = touch_spare ? 0 : 1; w < 3; w++)
        begin
            cfg_valid = 1'b1;
            cfg_index = idx[w];
            cfg_data  = val[w];
            do
                @(posedge clk);
            while (!cfg_ready);
            @(negedge clk);
        end
        cfg_valid = 1'b0;
    endtask

    // Random traffic in stretches of thirty items, each with its own mix of
    // adds and ticks: a tick-heavy mix empties the table and reaches idle
    // ticks, an add-heavy one fills it and reaches rejections. Most bursts are
    // short so that processes keep finishing; a few are long or zero.
    task automatic random_run(input int count);
        int add_pct;
        int r;
        logic [LEN_W-1:0] len;
        add_pct = 30;
        for (int i = 0; i < count; i++)
        begin
            if (i % 30 == 0)
            begin
                r = $urandom_range(2, 0);
                add_pct = (r == 0) ? 15 : (r == 1) ? 35 : 70;
            end
            // Now and then the sender holds back until the block has caught up.
            if ($urandom_range(99, 0) < 2)
                drain();
            if ($urandom_range(99, 0) < add_pct)
            begin
                r = $urandom_range(99, 0);
                if (r < 5)
                    len = '0;
                else if (r < 88)
                    len = LEN_W'($urandom_range(4, 1));
                else if (r < 99)
                    len = LEN_W'($urandom_range(64, 5));
                else
                    len = LEN_W'($urandom);
                send_item(CMD_ADD, ID_W'($urandom), len);
            end
            else
                send_item(CMD_TICK, ID_W'($urandom), LEN_W'($urandom));
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        command         = CMD_ADD;
        process_id      = '0;
        burst_length    = '0;
        cfg_valid       = 1'b0;
        cfg_index       = REG_RUN_GAIN;
        cfg_data        = '0;
        sender_idle_pct = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed part, with the gains at their reset values.
        // A tick on an empty table reports idle, and a zero burst is refused.
        send_item(CMD_TICK, 8'h00, 16'h0000);
        send_item(CMD_ADD, 8'h00, 16'h0000);
        // Three adds into an empty table, two of them sharing an id. The first
        // tick has no current process yet and must pick the lowest slot on the
        // all-zero priority tie. Six ticks run all three to completion.
        send_item(CMD_ADD, 8'hFF, 16'h0001);
        send_item(CMD_ADD, 8'h5A, 16'h0003);
        send_item(CMD_ADD, 8'h5A, 16'h0002);
        repeat (6) send_item(CMD_TICK, 8'hFF, 16'hFFFF);
        // Fill every slot with short jobs; the add after that is refused.
        for (int k = 0; k < SLOTS_DEF; k++)
            send_item(CMD_ADD, 8'(k * 17), 16'(k % 2 + 1));
        send_item(CMD_ADD, 8'hFF, 16'hFFFF);

        // Random part. The sender first idles rarely, then often, then never.
        // Gains go through both extremes, and the spare index gets written too.
        sender_idle_pct = 6;
        program_gains(4'd0, 4'd0, 1'b0);
        random_run(250);
        program_gains(4'd15, 4'd1, 1'b0);
        random_run(250);
        sender_idle_pct = 76;
        program_gains(4'd3, 4'd15, 1'b1);
        random_run(250);
        sender_idle_pct = 0;
        program_gains(GAIN_W'($urandom), GAIN_W'($urandom), 1'b1);
        random_run(250);

        // Equal-gain run: with both gains at their maximum every live process
        // gains the same amount per tick, so priority ties keep arising and the
        // waiting-wins tie rule decides them.
        program_gains(4'd15, 4'd15, 1'b0);
        send_item(CMD_ADD, 8'h3C, 16'd40);
        send_item(CMD_ADD, 8'hC3, 16'd40);
        repeat (70) send_item(CMD_TICK, ID_W'($urandom), LEN_W'($urandom));

        // Let the last results arrive, then give the block time to show any
        // stray strobe before the verdict.
        drain();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("aging_priority_scheduler_top regression: pass");
        else
            $display("aging_priority_scheduler_top regression: fail");
        $finish;
    end

endmodule
